FILE: rtl/assert_macros.svh
// assertion macros shared by the fill blitter modules
// expects a clock named clk and an active-low reset named arst_n in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define CRFB_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// condition must never be seen outside reset
`define CRFB_NEVER(lbl, cond, msg) \
	`CRFB_ASSERT(lbl, !(cond), msg)

`endif

FILE: rtl/crfb_pkg.sv
// shared types and constants of the 2bpp rectangle fill blitter
// no dependencies; imported by front, back and top level
package crfb_pkg;

	// default canvas store geometry
	localparam int MAX_CANVAS_WIDTH_DEF = 256;
	localparam int MAX_CANVAS_ROWS_DEF  = 256;

	// configuration port
	localparam int CFG_W     = 9;
	localparam int CFG_IDX_W = 2;
	localparam int LINE_W    = 7;
	localparam logic [CFG_IDX_W-1:0] REG_CANVAS_WIDTH   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CANVAS_ROWS    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BOX_LINE_WIDTH = 2'd2;
	localparam logic [CFG_W-1:0]  CANVAS_WIDTH_RST   = 9'd256;
	localparam logic [CFG_W-1:0]  CANVAS_ROWS_RST    = 9'd256;
	localparam logic [LINE_W-1:0] BOX_LINE_WIDTH_RST = 7'd2;

	// canvas width is aligned down to 16 pixels, both sizes held at 16 or more
	localparam logic [CFG_W-1:0] WIDTH_ALIGN_MASK = 9'h1F0;
	localparam int MIN_CANVAS = 16;

	// signed coordinate width wide enough for position plus extent
	localparam int COORD_W = 14;

	// stream widths
	localparam int IN_TDATA_W  = 56;
	localparam int OUT_TDATA_W = 16;

	localparam int JOB_QUEUE_DEPTH = 4;

	// command beat, mode in the lowest bits
	typedef struct packed {
		logic [1:0]         colour_value;
		logic [11:0]        rect_height;
		logic [11:0]        rect_width;
		logic signed [12:0] top_y;
		logic signed [12:0] left_x;
		logic [1:0]         mode;
	} cmd_t;
	localparam int CMD_W = $bits(cmd_t);

	// result beat, read_byte in the lowest bits
	typedef struct packed {
		logic       painted;
		logic [7:0] read_byte;
	} result_t;

	// work unit handed from front to back
	typedef enum logic [1:0] {JOB_SKIP, JOB_FILL, JOB_READ} job_kind_t;

	typedef struct packed {
		job_kind_t  kind;
		logic       last;
		logic [7:0] pattern;
	} job_ctl_t;
	localparam int JOB_CTL_W = $bits(job_ctl_t);

endpackage

FILE: rtl/crfb_queue.sv
// short fifo between command front end and fill engine
// generic; no package dependency beyond the default depth
module crfb_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = crfb_pkg::JOB_QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	output logic             push_ready,
	input  logic [WIDTH-1:0] push_data,
	output logic             pop_valid,
	input  logic             pop_ready,
	output logic [WIDTH-1:0] pop_data
);
	localparam int PW = $clog2(DEPTH);

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [PW:0]      count_q;
	logic             do_push, do_pop;

	assign push_ready = (count_q != (PW+1)'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_data   = slot_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	// storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : PW'(wr_ptr_q + 1'b1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : PW'(rd_ptr_q + 1'b1);
			end
			if (do_push && !do_pop) begin
				count_q <= (PW+1)'(count_q + 1'b1);
			end else if (do_pop && !do_push) begin
				count_q <= (PW+1)'(count_q - 1'b1);
			end
		end
	end

endmodule

FILE: rtl/crfb_front.sv
// command front end: decodes a command and emits clipped fill, read or skip jobs
// depends on crfb_pkg and assert_macros.svh
`include "assert_macros.svh"

module crfb_front #(
	parameter int MAX_CANVAS_WIDTH = crfb_pkg::MAX_CANVAS_WIDTH_DEF,
	parameter int MAX_CANVAS_ROWS  = crfb_pkg::MAX_CANVAS_ROWS_DEF
) (
	input  logic                                          clk,
	input  logic                                          arst_n,
	input  logic                                          cmd_valid,
	output logic                                          cmd_ready,
	input  crfb_pkg::cmd_t                                cmd,
	input  logic [$clog2(MAX_CANVAS_WIDTH + 1)-1:0]       cw,
	input  logic [$clog2(MAX_CANVAS_ROWS + 1)-1:0]        cr,
	input  logic [crfb_pkg::LINE_W-1:0]                   lw,
	input  logic                                          init_busy,
	output logic                                          job_valid,
	input  logic                                          job_ready,
	output crfb_pkg::job_ctl_t                            job_ctl,
	output logic [$clog2(MAX_CANVAS_ROWS + 1)-1:0]        job_row0,
	output logic [$clog2(MAX_CANVAS_ROWS + 1)-1:0]        job_row1,
	output logic [$clog2(MAX_CANVAS_WIDTH / 4 + 1)-1:0]   job_byte0,
	output logic [$clog2(MAX_CANVAS_WIDTH / 4 + 1)-1:0]   job_byte1
);
	import crfb_pkg::*;

	localparam int RW = $clog2(MAX_CANVAS_ROWS + 1);
	localparam int BW = $clog2(MAX_CANVAS_WIDTH / 4 + 1);

	typedef enum logic [1:0] {MODE_CLEAR, MODE_FILL, MODE_HOLLOW, MODE_READ} mode_t;
	typedef enum logic {F_IDLE, F_EMIT} fstate_t;

	// hollow box edges in emit order
	localparam logic [1:0] EDGE_TOP    = 2'd0;
	localparam logic [1:0] EDGE_BOTTOM = 2'd1;
	localparam logic [1:0] EDGE_LEFT   = 2'd2;
	localparam logic [1:0] EDGE_RIGHT  = 2'd3;

	fstate_t                    state_q;
	logic [1:0]                 step_q;
	mode_t                      mode_q;
	logic                       hollow4_q;
	logic [1:0]                 last_step_q;
	logic signed [COORD_W-1:0]  x_q, y_q, w_q, h_q, xr_q, yb_q;
	logic [7:0]                 pat_q;

	logic signed [COORD_W-1:0]  in_x, in_y, in_w, in_h, lw_s, cw_s, cr_s;
	logic [LINE_W:0]            two_lw;
	logic                       in_hollow4;
	logic signed [COORD_W-1:0]  fx, fy, fw, fh, fx0, fx1, fy0, fy1;
	logic                       f_empty, rd_in;

	// accept-side decode
	assign in_x   = {cmd.left_x[12], cmd.left_x};
	assign in_y   = {cmd.top_y[12], cmd.top_y};
	assign in_w   = {2'b00, cmd.rect_width};
	assign in_h   = {2'b00, cmd.rect_height};
	assign lw_s   = COORD_W'(lw);
	assign cw_s   = COORD_W'(cw);
	assign cr_s   = COORD_W'(cr);
	assign two_lw = {lw, 1'b0};
	assign in_hollow4 = (mode_t'(cmd.mode) == MODE_HOLLOW)
		&& !(cmd.rect_width < 12'(two_lw) || cmd.rect_height < 12'(two_lw));

	assign cmd_ready = (state_q == F_IDLE) && !init_busy;
	assign job_valid = (state_q == F_EMIT);

	// command latch
	always_ff @(posedge clk) begin
		if (cmd_valid && cmd_ready) begin
			mode_q      <= mode_t'(cmd.mode);
			hollow4_q   <= in_hollow4;
			last_step_q <= in_hollow4 ? EDGE_RIGHT : EDGE_TOP;
			x_q         <= in_x;
			y_q         <= in_y;
			w_q         <= in_w;
			h_q         <= in_h;
			xr_q        <= in_x + in_w - lw_s;
			yb_q        <= in_y + in_h - lw_s;
			pat_q       <= {4{cmd.colour_value}};
		end
	end

	// sequencer over the jobs of one command
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			step_q  <= EDGE_TOP;
		end else begin
			case (state_q)
				F_IDLE: begin
					if (cmd_valid && cmd_ready) begin
						state_q <= F_EMIT;
						step_q  <= EDGE_TOP;
					end
				end
				F_EMIT: begin
					if (job_ready) begin
						if (job_ctl.last) begin
							state_q <= F_IDLE;
						end else begin
							step_q <= 2'(step_q + 1'b1);
						end
					end
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

	// pick the rectangle of the current edge and clip it to the canvas
	always_comb begin
		fx = x_q;
		fy = y_q;
		fw = w_q;
		fh = h_q;
		if (hollow4_q) begin
			case (step_q)
				EDGE_TOP:    fh = lw_s;
				EDGE_BOTTOM: begin
					fy = yb_q;
					fh = lw_s;
				end
				EDGE_LEFT:   fw = lw_s;
				default: begin
					fx = xr_q;
					fw = lw_s;
				end
			endcase
		end
		fx0 = (fx < 0) ? '0 : fx;
		fy0 = (fy < 0) ? '0 : fy;
		fx1 = fx + fw;
		fy1 = fy + fh;
		if (fx1 > cw_s) fx1 = cw_s;
		if (fy1 > cr_s) fy1 = cr_s;
		f_empty = (fx1 <= fx0) || (fy1 <= fy0);
	end

	assign rd_in = (x_q >= 0) && (y_q >= 0) && (x_q < cw_s) && (y_q < cr_s);

	// job fields
	always_comb begin
		job_ctl.last    = (step_q == last_step_q);
		job_ctl.pattern = pat_q;
		job_ctl.kind    = f_empty ? JOB_SKIP : JOB_FILL;
		job_row0        = RW'(fy0);
		job_row1        = RW'(fy1);
		job_byte0       = BW'(fx0 >>> 2);
		job_byte1       = BW'((fx1 + 3) >>> 2);
		case (mode_q)
			MODE_CLEAR: begin
				job_ctl.kind    = JOB_FILL;
				job_ctl.pattern = '0;
				job_row0        = '0;
				job_row1        = cr;
				job_byte0       = '0;
				job_byte1       = BW'(cw >> 2);
			end
			MODE_READ: begin
				job_ctl.kind = rd_in ? JOB_READ : JOB_SKIP;
				job_row0     = RW'(y_q);
				job_row1     = '0;
				job_byte0    = BW'(x_q >>> 2);
				job_byte1    = '0;
			end
			default: ;
		endcase
	end

	`CRFB_ASSERT(a_read_is_last, (job_valid && job_ctl.kind == JOB_READ) |-> job_ctl.last, "read job not last of its command")
	`CRFB_ASSERT(a_multi_only_hollow, (state_q == F_EMIT && step_q != last_step_q) |-> (mode_q == MODE_HOLLOW), "several jobs for a non-box command")
	`CRFB_NEVER(a_step_range, state_q == F_EMIT && step_q > last_step_q, "edge step ran past the last edge")

endmodule

FILE: rtl/crfb_back.sv
// fill engine: owns the canvas memory, runs fills, reads and the reset clear
// depends on crfb_pkg and assert_macros.svh
`include "assert_macros.svh"

module crfb_back #(
	parameter int MAX_CANVAS_WIDTH = crfb_pkg::MAX_CANVAS_WIDTH_DEF,
	parameter int MAX_CANVAS_ROWS  = crfb_pkg::MAX_CANVAS_ROWS_DEF
) (
	input  logic                                          clk,
	input  logic                                          arst_n,
	input  logic                                          job_valid,
	output logic                                          job_ready,
	input  crfb_pkg::job_ctl_t                            job_ctl,
	input  logic [$clog2(MAX_CANVAS_ROWS + 1)-1:0]        job_row0,
	input  logic [$clog2(MAX_CANVAS_ROWS + 1)-1:0]        job_row1,
	input  logic [$clog2(MAX_CANVAS_WIDTH / 4 + 1)-1:0]   job_byte0,
	input  logic [$clog2(MAX_CANVAS_WIDTH / 4 + 1)-1:0]   job_byte1,
	input  logic [$clog2(MAX_CANVAS_WIDTH / 4 + 1)-1:0]   stride,
	output logic                                          init_busy,
	output logic                                          res_valid,
	input  logic                                          res_ready,
	output crfb_pkg::result_t                             res
);
	import crfb_pkg::*;

	localparam int RW          = $clog2(MAX_CANVAS_ROWS + 1);
	localparam int BW          = $clog2(MAX_CANVAS_WIDTH / 4 + 1);
	localparam int STORE_BYTES = (MAX_CANVAS_WIDTH / 4) * MAX_CANVAS_ROWS;
	localparam int AW          = $clog2(STORE_BYTES);

	typedef enum logic [2:0] {
		ST_INIT, ST_IDLE, ST_SETUP, ST_FILL, ST_RD_REQ, ST_RD_DATA, ST_DONE
	} bstate_t;

	bstate_t         state_q;
	logic [RW-1:0]   row_q, row1_q;
	logic [BW-1:0]   col_q, byte0_q, byte1_q;
	logic [7:0]      pat_q;
	job_kind_t       kind_q;
	logic            last_q;
	logic [AW-1:0]   base_q, clr_addr_q;
	logic            painted_acc_q;
	logic [7:0]      res_byte_q;
	logic            res_valid_q;
	result_t         res_q;

	logic [7:0]      canvas_q [STORE_BYTES];
	logic [7:0]      mem_rd_q;
	logic            mem_we, mem_re;
	logic [AW-1:0]   mem_addr, mem_wa;
	logic [7:0]      mem_wd;
	logic            col_end, row_end, out_free;

	assign job_ready = (state_q == ST_IDLE);
	assign init_busy = (state_q == ST_INIT);
	assign res_valid = res_valid_q;
	assign res       = res_q;
	assign out_free  = !res_valid_q || res_ready;
	assign col_end   = (BW'(col_q + 1'b1) == byte1_q);
	assign row_end   = (RW'(row_q + 1'b1) == row1_q);

	// memory port control
	assign mem_addr = base_q + AW'(col_q);
	assign mem_we   = (state_q == ST_INIT) || (state_q == ST_FILL);
	assign mem_wa   = (state_q == ST_INIT) ? clr_addr_q : mem_addr;
	assign mem_wd   = (state_q == ST_INIT) ? '0 : pat_q;
	assign mem_re   = (state_q == ST_RD_REQ);

	// canvas store
	always_ff @(posedge clk) begin
		if (mem_we) begin
			canvas_q[mem_wa] <= mem_wd;
		end
		if (mem_re) begin
			mem_rd_q <= canvas_q[mem_addr];
		end
	end

	// engine state, walk counters and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_INIT;
			clr_addr_q    <= '0;
			row_q         <= '0;
			row1_q        <= '0;
			col_q         <= '0;
			byte0_q       <= '0;
			byte1_q       <= '0;
			pat_q         <= '0;
			kind_q        <= JOB_SKIP;
			last_q        <= 1'b0;
			base_q        <= '0;
			painted_acc_q <= 1'b0;
			res_byte_q    <= '0;
			res_valid_q   <= 1'b0;
			res_q         <= '0;
		end else begin
			// result valid: set by a finished command, cleared once taken
			if (state_q == ST_DONE && out_free) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				// clearing pass over the whole store after reset
				ST_INIT: begin
					clr_addr_q <= AW'(clr_addr_q + 1'b1);
					if (clr_addr_q == AW'(STORE_BYTES - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (job_valid) begin
						row_q   <= job_row0;
						row1_q  <= job_row1;
						col_q   <= job_byte0;
						byte0_q <= job_byte0;
						byte1_q <= job_byte1;
						pat_q   <= job_ctl.pattern;
						kind_q  <= job_ctl.kind;
						last_q  <= job_ctl.last;
						case (job_ctl.kind)
							JOB_FILL: begin
								painted_acc_q <= 1'b1;
								state_q       <= ST_SETUP;
							end
							JOB_READ: state_q <= ST_SETUP;
							default:  state_q <= job_ctl.last ? ST_DONE : ST_IDLE;
						endcase
					end
				end
				// row base address of the first row
				ST_SETUP: begin
					base_q  <= AW'(row_q) * AW'(stride);
					state_q <= (kind_q == JOB_READ) ? ST_RD_REQ : ST_FILL;
				end
				// one byte per cycle, row by row
				ST_FILL: begin
					if (col_end) begin
						col_q  <= byte0_q;
						row_q  <= RW'(row_q + 1'b1);
						base_q <= base_q + AW'(stride);
						if (row_end) begin
							state_q <= last_q ? ST_DONE : ST_IDLE;
						end
					end else begin
						col_q <= BW'(col_q + 1'b1);
					end
				end
				ST_RD_REQ: state_q <= ST_RD_DATA;
				ST_RD_DATA: begin
					res_byte_q <= mem_rd_q;
					state_q    <= ST_DONE;
				end
				// hand the command result to the output register
				ST_DONE: begin
					if (out_free) begin
						res_q.read_byte   <= res_byte_q;
						res_q.painted     <= painted_acc_q;
						painted_acc_q     <= 1'b0;
						res_byte_q        <= '0;
						state_q           <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	`CRFB_ASSERT(a_fill_in_span, (state_q == ST_FILL) |-> (col_q < byte1_q && row_q < row1_q), "fill walk left its span")
	`CRFB_ASSERT(a_write_in_store, mem_we |-> ({1'b0, mem_wa} < (AW+1)'(STORE_BYTES)), "canvas write outside the store")
	`CRFB_ASSERT(a_read_byte_clean, (state_q == ST_RD_REQ) |-> (res_byte_q == '0), "stale read byte before a read")

endmodule

FILE: rtl/clipped_rect_and_box_fill_2bpp.sv
// Rectangle fill blitter on a 2-bit-per-pixel canvas kept in an internal byte
// memory of (MAX_CANVAS_WIDTH/4)*MAX_CANVAS_ROWS bytes. Each command beat clears
// the active canvas, fills a clipped rectangle, draws a hollow box, or reads one
// byte, and gives exactly one result beat. After reset the block clears the whole
// memory, one byte a cycle, and takes no command while it does so; configuration
// writes are taken throughout. Command cost is set by the single write port of
// the canvas memory, one byte per cycle: a fill has a setup step and then writes
// each covered byte (clipped rows times byte span); a hollow box is four such
// fills, or one plain fill when it is narrower or lower than twice the line
// width; a clear fills the whole active canvas; a read issues a memory request
// and then captures the byte. The result then goes to the output register. Decode
// sits ahead of the job queue, and the short job queue lets the front end decode
// the next command while the engine still writes.
// depends on crfb_pkg, crfb_front, crfb_queue, crfb_back
module clipped_rect_and_box_fill_2bpp #(
	parameter int MAX_CANVAS_WIDTH = crfb_pkg::MAX_CANVAS_WIDTH_DEF,
	parameter int MAX_CANVAS_ROWS  = crfb_pkg::MAX_CANVAS_ROWS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [crfb_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [crfb_pkg::CFG_W-1:0]        cfg_data,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	// mode, left_x, top_y, rect_width, rect_height, colour_value, zero pad
	input  logic [crfb_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// read_byte, painted, zero pad
	output logic [crfb_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);
	import crfb_pkg::*;

	localparam int CW_W  = $clog2(MAX_CANVAS_WIDTH + 1);
	localparam int RW    = $clog2(MAX_CANVAS_ROWS + 1);
	localparam int BW    = $clog2(MAX_CANVAS_WIDTH / 4 + 1);
	localparam int JOB_W = 2 * RW + 2 * BW + JOB_CTL_W;

	logic [CFG_W-1:0]   width_q, rows_q;
	logic [LINE_W-1:0]  line_q;
	logic [COORD_W-1:0] cw_raw, cr_raw;
	logic [CW_W-1:0]    cw_eff;
	logic [RW-1:0]      cr_eff;
	logic [BW-1:0]      stride;

	cmd_t               cmd;
	result_t            res;
	logic               init_busy;

	logic               push_valid, push_ready, pop_valid, pop_ready;
	logic [JOB_W-1:0]   push_data, pop_data;
	job_ctl_t           f_ctl, b_ctl;
	logic [RW-1:0]      f_row0, f_row1, b_row0, b_row1;
	logic [BW-1:0]      f_byte0, f_byte1, b_byte0, b_byte1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= CANVAS_WIDTH_RST;
			rows_q  <= CANVAS_ROWS_RST;
			line_q  <= BOX_LINE_WIDTH_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_CANVAS_WIDTH:   width_q <= cfg_data;
				REG_CANVAS_ROWS:    rows_q  <= cfg_data;
				REG_BOX_LINE_WIDTH: line_q  <= cfg_data[LINE_W-1:0];
				default: ;
			endcase
		end
	end

	// effective canvas size
	assign cw_raw = COORD_W'(width_q & WIDTH_ALIGN_MASK);
	assign cr_raw = COORD_W'(rows_q);

	always_comb begin
		if (cw_raw < COORD_W'(MIN_CANVAS)) begin
			cw_eff = CW_W'(MIN_CANVAS);
		end else if (cw_raw > COORD_W'(MAX_CANVAS_WIDTH)) begin
			cw_eff = CW_W'(MAX_CANVAS_WIDTH);
		end else begin
			cw_eff = CW_W'(cw_raw);
		end
		if (cr_raw < COORD_W'(MIN_CANVAS)) begin
			cr_eff = RW'(MIN_CANVAS);
		end else if (cr_raw > COORD_W'(MAX_CANVAS_ROWS)) begin
			cr_eff = RW'(MAX_CANVAS_ROWS);
		end else begin
			cr_eff = RW'(cr_raw);
		end
	end

	assign stride = BW'(cw_eff >> 2);

	// stream beats
	assign cmd           = cmd_t'(s_axis_tdata[CMD_W-1:0]);
	assign m_axis_tdata  = OUT_TDATA_W'(res);

	crfb_front #(
		.MAX_CANVAS_WIDTH (MAX_CANVAS_WIDTH),
		.MAX_CANVAS_ROWS  (MAX_CANVAS_ROWS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (s_axis_tvalid),
		.cmd_ready (s_axis_tready),
		.cmd       (cmd),
		.cw        (cw_eff),
		.cr        (cr_eff),
		.lw        (line_q),
		.init_busy (init_busy),
		.job_valid (push_valid),
		.job_ready (push_ready),
		.job_ctl   (f_ctl),
		.job_row0  (f_row0),
		.job_row1  (f_row1),
		.job_byte0 (f_byte0),
		.job_byte1 (f_byte1)
	);

	// job queue between decode and fill engine
	assign push_data = {f_row0, f_row1, f_byte0, f_byte1, f_ctl};
	assign {b_row0, b_row1, b_byte0, b_byte1, b_ctl} = pop_data;

	crfb_queue #(
		.WIDTH (JOB_W),
		.DEPTH (JOB_QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	crfb_back #(
		.MAX_CANVAS_WIDTH (MAX_CANVAS_WIDTH),
		.MAX_CANVAS_ROWS  (MAX_CANVAS_ROWS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (pop_valid),
		.job_ready (pop_ready),
		.job_ctl   (b_ctl),
		.job_row0  (b_row0),
		.job_row1  (b_row1),
		.job_byte0 (b_byte0),
		.job_byte1 (b_byte1),
		.stride    (stride),
		.init_busy (init_busy),
		.res_valid (m_axis_tvalid),
		.res_ready (m_axis_tready),
		.res       (res)
	);

endmodule
